[hw/rtl/crc6sc_pkg.sv]
// shared types and constants for the crc-6 stream checker
package crc6sc_pkg;

  localparam int unsigned CrcW = 6;
  localparam int unsigned SymW = 8;
  localparam int unsigned SymShortW = 6;

  localparam logic [CrcW:0]   CRC_FEEDBACK = 7'h43;
  localparam logic [CrcW-1:0] CRC_XOROUT   = 6'h3f;
  localparam logic [CrcW-1:0] CRC_INIT     = 6'h00;

  localparam logic [0:0] REG_SIX_BIT_SYMBOLS   = 1'b0;
  localparam logic [0:0] REG_APPEND_ZERO_FLUSH = 1'b1;

  typedef struct packed {
    logic six_bit_symbols;
    logic append_zero_flush;
  } crc6sc_mode_t;

endpackage

[hw/rtl/crc6sc_step.sv]
// one symbol of crc-6 division plus optional zero flush and final xor
module crc6sc_step import crc6sc_pkg::*; (
  input  logic [CrcW-1:0] rem_in,
  input  logic [SymW-1:0] symbol_data,
  input  logic            last_symbol,
  input  crc6sc_mode_t    mode,
  output logic [CrcW-1:0] rem_out,
  output logic [CrcW-1:0] crc_value
);

  logic [CrcW-1:0] sym_rem;
  logic [CrcW:0]   flush_t;
  logic [CrcW-1:0] flush_rem;
  logic [CrcW-1:0] final_rem;

  // bitwise division, msb first; short symbols skip the top two bits
  always_comb begin
    logic [CrcW:0] t;
    sym_rem = rem_in;
    for (int i = SymW - 1; i >= 0; i--) begin
      t = {sym_rem, symbol_data[i]};
      if (t[CrcW]) begin
        t = t ^ CRC_FEEDBACK;
      end
      if (!(mode.six_bit_symbols && (i >= SymShortW))) begin
        sym_rem = t[CrcW-1:0];
      end
    end
  end

  // six zero bits equal multiply by x^6 = x + 1, then one reduction
  always_comb begin
    flush_t = {sym_rem, 1'b0} ^ {1'b0, sym_rem};
    if (flush_t[CrcW]) begin
      flush_t = flush_t ^ CRC_FEEDBACK;
    end
    flush_rem = flush_t[CrcW-1:0];
  end

  assign final_rem = mode.append_zero_flush ? flush_rem : sym_rem;
  assign crc_value = final_rem ^ CRC_XOROUT;
  assign rem_out   = last_symbol ? CRC_INIT : sym_rem;

endmodule

[hw/rtl/crc6_stream_checker_unit.sv]
// crc-6 stream checker top level
//
// symbols enter on the in_ channel (valid/ready), msb first; in_last_symbol
// marks the final symbol of a message. one crc beat leaves on the out_
// channel per message, holding the remainder xor 0x3f. generator is
// x^6 + x + 1, starting remainder zero.
// cfg_ channel writes index 0 (six-bit symbols) and index 1 (zero flush);
// cfg_ready is always high, writes belong between messages.
// pipeline: input register, then xor logic into the running remainder and
// the result register, which drives out_valid; a last symbol passes both
// in that order. one symbol is taken every cycle while in_ready is high.
// when the receiver stalls, the result holds in the output register and
// the input register keeps filling; middle symbols still drain, and only a
// second last symbol waits, which then pulls in_ready low.
// synchronous active-low reset empties both registers, clears the
// remainder and sets six-bit mode off and zero flush on.
module crc6_stream_checker_unit import crc6sc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [SymW-1:0] in_symbol_data,
  input  logic            in_last_symbol,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CrcW-1:0] out_crc_value,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [0:0]      cfg_index,
  input  logic            cfg_data
);

  crc6sc_mode_t    mode_r;
  crc6sc_mode_t    mode_nxt;
  logic            s1_valid_r;
  logic            s1_valid_nxt;
  logic [SymW-1:0] s1_symbol_r;
  logic            s1_last_r;
  crc6sc_mode_t    s1_mode_r;
  logic [CrcW-1:0] rem_r;
  logic [CrcW-1:0] rem_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic [CrcW-1:0] out_crc_r;
  logic [CrcW-1:0] crc_nxt;
  logic            advance;
  logic            in_fire;

  assign cfg_ready = 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_SIX_BIT_SYMBOLS:   mode_nxt.six_bit_symbols   = cfg_data;
        REG_APPEND_ZERO_FLUSH: mode_nxt.append_zero_flush = cfg_data;
        default:               mode_nxt = mode_r;
      endcase
    end
  end

  crc6sc_step u_step (
    .rem_in      (rem_r),
    .symbol_data (s1_symbol_r),
    .last_symbol (s1_last_r),
    .mode        (s1_mode_r),
    .rem_out     (rem_nxt),
    .crc_value   (crc_nxt)
  );

  // middle symbols never need the output register
  assign advance  = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !advance);
  assign out_valid_nxt = (advance && s1_last_r) || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= '{six_bit_symbols: 1'b0, append_zero_flush: 1'b1};
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rem_r       <= CRC_INIT;
    end else begin
      mode_r      <= mode_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        rem_r <= rem_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_symbol_r <= in_symbol_data;
      s1_last_r   <= in_last_symbol;
      s1_mode_r   <= mode_r;
    end
    if (advance && s1_last_r) begin
      out_crc_r <= crc_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

  // remainder restarts after every message
  a_rem_clear: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_last_r |=> rem_r == CRC_INIT)
    else $error("remainder not cleared after last symbol");

  // a finished message always reaches the output register
  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_last_r |=> out_valid_r)
    else $error("last symbol did not produce a result");

  // input only stalls behind a waiting result and a waiting last symbol
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && s1_last_r && out_valid_r && !out_ready)
    else $error("input stalled without cause");

  // stalled result is not overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_crc_r))
    else $error("result lost under stall");

endmodule

[bench/crc6_stream_checker_unit_test.sv]
// self-checking testbench for the crc-6 stream checker unit
`timescale 1ns / 1ps

module crc6_stream_checker_unit_test;
  import crc6sc_pkg::*;

  localparam int unsigned RandomSymbols = 750;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 4;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_RUNS
  } stall_mode_e;

  typedef struct packed {
    logic            six_bit_symbols;
    logic            append_zero_flush;
    logic [SymW-1:0] symbol_data;
    logic            last_symbol;
    logic            typed;
    logic [CrcW-1:0] typed_crc;
  } stim_row_t;

  localparam int unsigned PlanRows = 22;
  localparam stim_row_t PLAN [0:PlanRows-1] = '{
    // reset settings: 8-bit symbols, zero flush on
    '{1'b0, 1'b1, 8'h00, 1'b1, 1'b1, 6'h3f},
    '{1'b0, 1'b1, 8'hff, 1'b1, 1'b0, 6'h00},
    '{1'b0, 1'b1, 8'h80, 1'b1, 1'b0, 6'h00},
    '{1'b0, 1'b1, 8'h01, 1'b0, 1'b0, 6'h00},
    '{1'b0, 1'b1, 8'hfe, 1'b1, 1'b0, 6'h00},
    // no flush
    '{1'b0, 1'b0, 8'h3f, 1'b1, 1'b1, 6'h00},
    '{1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 6'h3f},
    '{1'b0, 1'b0, 8'hff, 1'b1, 1'b0, 6'h00},
    // six-bit symbols, upper bits ignored
    '{1'b1, 1'b0, 8'h3f, 1'b1, 1'b1, 6'h00},
    '{1'b1, 1'b0, 8'hc0, 1'b1, 1'b1, 6'h3f},
    '{1'b1, 1'b0, 8'hff, 1'b1, 1'b1, 6'h00},
    '{1'b1, 1'b1, 8'h2a, 1'b0, 1'b0, 6'h00},
    '{1'b1, 1'b1, 8'h15, 1'b0, 1'b0, 6'h00},
    '{1'b1, 1'b1, 8'h3f, 1'b1, 1'b0, 6'h00},
    '{1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 6'h3f},
    // settings change in the middle of a message
    '{1'b0, 1'b1, 8'ha5, 1'b0, 1'b0, 6'h00},
    '{1'b1, 1'b0, 8'h5a, 1'b1, 1'b0, 6'h00},
    '{1'b1, 1'b0, 8'h40, 1'b0, 1'b0, 6'h00},
    '{1'b0, 1'b1, 8'h81, 1'b1, 1'b0, 6'h00},
    '{1'b0, 1'b1, 8'h7f, 1'b0, 1'b0, 6'h00},
    '{1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 6'h00},
    '{1'b0, 1'b1, 8'hff, 1'b1, 1'b0, 6'h00}
  };

  logic            clk;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [SymW-1:0] in_symbol_data = '0;
  logic            in_last_symbol = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b1;
  logic [CrcW-1:0] out_crc_value;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [0:0]      cfg_index = REG_SIX_BIT_SYMBOLS;
  logic            cfg_data = 1'b0;

  crc6sc_mode_t    mode_q;
  logic [CrcW-1:0] running_rem;
  logic [CrcW-1:0] crc_expected_q [$];
  logic [CrcW-1:0] crc_wanted;
  stall_mode_e     stall_mode = STALL_NONE;
  int unsigned     run_left = 0;
  logic            run_level = 1'b1;
  bit              gaps_on = 1'b1;
  int unsigned     burst_left = 0;
  int unsigned     errors = 0;
  int unsigned     cycle_count = 0;
  int unsigned     symbols_sent = 0;
  int unsigned     messages_sent = 0;
  int unsigned     crc_beats = 0;
  int unsigned     settings_count = 0;

  crc6_stream_checker_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_symbol_data(in_symbol_data),
    .in_last_symbol(in_last_symbol),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_crc_value (out_crc_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [CrcW-1:0] crc6_shift(input logic [CrcW-1:0] rem,
                                                 input logic bit_in);
    logic [CrcW:0] t;
    t = {rem, bit_in};
    if (t[CrcW]) begin
      t = t ^ CRC_FEEDBACK;
    end
    return t[CrcW-1:0];
  endfunction

  function automatic logic [CrcW-1:0] crc6_fold_symbol(input logic [CrcW-1:0] rem,
                                                       input logic [SymW-1:0] sym,
                                                       input logic six_bit);
    logic [CrcW-1:0] r;
    int              top;
    r = rem;
    top = six_bit ? SymShortW - 1 : SymW - 1;
    for (int i = top; i >= 0; i--) begin
      r = crc6_shift(r, sym[i]);
    end
    return r;
  endfunction

  task automatic send_symbol(input logic [SymW-1:0] sym, input logic is_last,
                             input logic typed, input logic [CrcW-1:0] typed_crc);
    int unsigned     gap;
    logic [CrcW-1:0] r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_symbol_data <= sym;
    in_last_symbol <= is_last;
    do @(posedge clk); while (!in_ready);
    symbols_sent++;
    r = crc6_fold_symbol(running_rem, sym, mode_q.six_bit_symbols);
    if (!is_last) begin
      running_rem = r;
    end else begin
      if (mode_q.append_zero_flush) begin
        repeat (CrcW) r = crc6_shift(r, 1'b0);
      end
      crc_expected_q.push_back(typed ? typed_crc : (r ^ CRC_XOROUT));
      running_rem = CRC_INIT;
      messages_sent++;
    end
  endtask

  // all crc beats back and any middle symbol drained from the pipeline
  task automatic settle_block();
    in_valid <= 1'b0;
    burst_left = 0;
    while (crc_expected_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_mode(input logic six_bit, input logic flush);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SIX_BIT_SYMBOLS;
    cfg_data  <= six_bit;
    do @(posedge clk); while (!cfg_ready);
    mode_q.six_bit_symbols = six_bit;
    cfg_index <= REG_APPEND_ZERO_FLUSH;
    cfg_data  <= flush;
    do @(posedge clk); while (!cfg_ready);
    mode_q.append_zero_flush = flush;
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (crc_expected_q.size() == 0) begin
        errors++;
        $display("%0t: crc beat with none expected, expected none, got %02h",
                 $time, out_crc_value);
      end else begin
        crc_wanted = crc_expected_q.pop_front();
        crc_beats++;
        if (out_crc_value !== crc_wanted) begin
          errors++;
          $display("%0t: crc mismatch, expected %02h, got %02h",
                   $time, crc_wanted, out_crc_value);
        end
      end
    end
    case (stall_mode)
      STALL_NONE: begin
        out_ready <= 1'b1;
      end
      STALL_RANDOM: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 10);
          run_level = ~run_level;
        end
        run_left--;
        out_ready <= run_level;
      end
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d crc beats outstanding",
               $time, cycle_count, crc_expected_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned     random_left;
    int unsigned     phase_len;
    int unsigned     msg_left;
    logic [SymW-1:0] sym;
    logic            is_last;

    mode_q.six_bit_symbols   = 1'b0;
    mode_q.append_zero_flush = 1'b1;
    running_rem = CRC_INIT;
    msg_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, reset settings first
    for (int i = 0; i < PlanRows; i++) begin
      if (PLAN[i].six_bit_symbols != mode_q.six_bit_symbols ||
          PLAN[i].append_zero_flush != mode_q.append_zero_flush) begin
        settle_block();
        set_mode(PLAN[i].six_bit_symbols, PLAN[i].append_zero_flush);
      end
      send_symbol(PLAN[i].symbol_data, PLAN[i].last_symbol, PLAN[i].typed,
                  PLAN[i].typed_crc);
    end

    // random phases; a phase may end mid-message so settings change under it
    random_left = RandomSymbols;
    while (random_left != 0) begin
      settle_block();
      set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      gaps_on = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(20, 90);
      while (phase_len != 0 && random_left != 0) begin
        if (msg_left == 0) begin
          msg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                 : $urandom_range(1, 4);
        end
        case ($urandom_range(0, 9))
          0:       sym = '0;
          1:       sym = '1;
          default: sym = SymW'($urandom_range(0, 255));
        endcase
        is_last = (msg_left == 1) || (random_left == 1);
        msg_left = is_last ? 0 : msg_left - 1;
        send_symbol(sym, is_last, 1'b0, '0);
        phase_len--;
        random_left--;
      end
    end

    in_valid <= 1'b0;
    while (crc_expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    errors += crc_expected_q.size();

    $display("sent %0d symbols in %0d messages under %0d register settings",
             symbols_sent, messages_sent, settings_count);
    $display("checked %0d crc beats with sender gaps and receiver stalls",
             crc_beats);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/crc6sc_pkg.sv
hw/rtl/crc6sc_step.sv
hw/rtl/crc6_stream_checker_unit.sv
bench/crc6_stream_checker_unit_test.sv
